// ===== rtl/core/prd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg
// shared constants, codes and controller/datapath handshake structs for the
// positional ring deque
// ----------------------------------------------------------------------------
package prd_pkg;

   // capacity is a power of two so ring indexes wrap by plain truncation
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int FILL_W     = ADDR_W + 1;
   localparam int POS_W      = 7;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   // width for comparing positions against the fill level
   localparam int CMP_W      = (POS_W > FILL_W) ? POS_W : FILL_W;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GET    = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_SWAP   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic ready;      // request port open
      logic accept;     // request taken this cycle
      logic rd_loc;     // read the addressed word (or first swap word)
      logic rd_b;       // read the second swap word
      logic copy;       // read next source word of a shift
      logic capture;    // hold the read word
      logic wr_swap_a;  // write second word into first place
      logic wr_swap_b;  // write held word into second place
      logic wr_word;    // write the inserted word
      logic load_rsp;   // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     req_valid;
      kind_type new_kind;
      logic     new_refused;
      logic     new_no_copy;
      kind_type cur_kind;
      logic     cur_no_copy;
      logic     cur_last;
      logic     out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/prd_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_req_if
// request channel: valid/ready handshake with kind, positions and data word
// ----------------------------------------------------------------------------
interface prd_req_if import prd_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [POS_W-1:0]      position;
   logic [POS_W-1:0]      second_position;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, output kind, output position,
                   output second_position, output value, input ready);
   modport sink   (input valid, input kind, input position,
                   input second_position, input value, output ready);

endinterface
`default_nettype wire

// ===== rtl/core/prd_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_rsp_if
// response channel: valid/ready handshake with read word, fill level, status
// ----------------------------------------------------------------------------
interface prd_rsp_if import prd_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] read_data;
   logic [FILL_W-1:0]     fill_level;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, output read_data, output fill_level,
                   output status, input ready);
   modport sink   (input valid, input read_data, input fill_level,
                   input status, output ready);

endinterface
`default_nettype wire

// ===== rtl/core/prd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module prd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/prd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_ctrl
// request sequencer: steps reads, shift copies and writes of one request
// ----------------------------------------------------------------------------
module prd_ctrl import prd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_READ   = 10'b00_0000_0010,
      S_CAPT   = 10'b00_0000_0100,
      S_SWAPB  = 10'b00_0000_1000,
      S_SWAPWA = 10'b00_0001_0000,
      S_SWAPWB = 10'b00_0010_0000,
      S_MOVE   = 10'b00_0100_0000,
      S_DRAIN  = 10'b00_1000_0000,
      S_INSW   = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = stat.req_valid;
            if (stat.req_valid) begin
               if (stat.new_refused) begin
                  state_in = S_DONE;
               end else if (stat.new_kind == KIND_INSERT) begin
                  state_in = stat.new_no_copy ? S_INSW : S_MOVE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_loc = 1'b1;
            state_in   = (stat.cur_kind == KIND_SWAP) ? S_SWAPB : S_CAPT;
         end
         S_CAPT: begin
            cmd.capture = 1'b1;
            if (stat.cur_kind == KIND_DELETE && !stat.cur_no_copy) begin
               state_in = S_MOVE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SWAPB: begin
            cmd.rd_b    = 1'b1;
            cmd.capture = 1'b1;
            state_in    = S_SWAPWA;
         end
         S_SWAPWA: begin
            cmd.wr_swap_a = 1'b1;
            state_in      = S_SWAPWB;
         end
         S_SWAPWB: begin
            cmd.wr_swap_b = 1'b1;
            state_in      = S_DONE;
         end
         S_MOVE: begin
            cmd.copy = 1'b1;
            if (stat.cur_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last copy write goes out on its own
            state_in = (stat.cur_kind == KIND_INSERT) ? S_INSW : S_DONE;
         end
         S_INSW: begin
            cmd.wr_word = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/prd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prd_datapath
// ring pointers, request decode, shift address walker, slot ram and
// response register
// ----------------------------------------------------------------------------
module prd_datapath import prd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   prd_req_if.sink       req_bus,
   prd_rsp_if.source     rsp_bus,
   input  wire cmd_type  cmd,
   output      stat_type stat
);

   // ring state
   addr_type            head_ff, head_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   // request registers
   kind_type            kind_ff, kind_in;
   status_type          status_ff, status_in;
   addr_type            addr_a_ff, addr_a_in;
   addr_type            addr_b_ff, addr_b_in;
   addr_type            src_ff, src_in;
   addr_type            count_ff, count_in;
   logic                step_dn_ff, step_dn_in;
   addr_type            word_addr_ff, word_addr_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] hold_ff, hold_in;

   // pending copy write
   logic                pend_ff, pend_in;
   addr_type            pend_addr_ff, pend_addr_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [FILL_W-1:0]     rsp_fill_ff, rsp_fill_in;
   status_type            rsp_status_ff, rsp_status_in;

   // decode of the offered request
   logic [CMP_W-1:0]  pos_a_x, pos_b_x, fill_x, last_x;
   addr_type          loc_a, loc_b, loc_i, phys_a, phys_b, fill_lo;
   logic [FILL_W:0]   half_ins;
   logic              ins_front, del_front;
   logic              new_refused;
   status_type        new_status;
   addr_type          new_head, new_count, new_src, new_word_addr;
   logic              new_step_dn;
   logic [FILL_W-1:0] new_fill;

   // ram
   logic                  ram_wr_en, ram_rd_en;
   addr_type              ram_wr_addr, ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data, ram_rd_data;

   assign pos_a_x  = CMP_W'(req_bus.position);
   assign pos_b_x  = CMP_W'(req_bus.second_position);
   assign fill_x   = CMP_W'(fill_ff);
   assign last_x   = fill_x - CMP_W'(1);
   assign loc_a    = ADDR_W'((pos_a_x >= fill_x) ? last_x : pos_a_x);
   assign loc_b    = ADDR_W'((pos_b_x >= fill_x) ? last_x : pos_b_x);
   assign loc_i    = ADDR_W'((pos_a_x > fill_x) ? fill_x : pos_a_x);
   assign phys_a   = head_ff + loc_a;
   assign phys_b   = head_ff + loc_b;
   assign fill_lo  = ADDR_W'(fill_ff);
   assign half_ins = ((FILL_W+1)'(fill_ff) + (FILL_W+1)'(1)) >> 1;
   assign ins_front = (FILL_W+1)'(loc_i) < half_ins;
   assign del_front = (fill_ff - FILL_W'(loc_a)) > FILL_W'(loc_a);

   always_comb begin
      new_refused   = 1'b0;
      new_status    = STAT_DONE;
      new_head      = head_ff;
      new_fill      = fill_ff;
      new_count     = '0;
      new_src       = phys_a;
      new_step_dn   = 1'b0;
      new_word_addr = phys_a;
      case (req_bus.kind)
         KIND_GET: begin
            new_refused = (fill_ff == '0);
         end
         KIND_INSERT: begin
            new_refused = (fill_ff == FILL_W'(CAPACITY));
            new_fill    = fill_ff + FILL_W'(1);
            if (ins_front) begin
               // front part slides down one place, head moves back
               new_head      = head_ff - ADDR_W'(1);
               new_count     = loc_i;
               new_src       = head_ff;
               new_step_dn   = 1'b0;
               new_word_addr = head_ff - ADDR_W'(1) + loc_i;
            end else begin
               // back part slides up one place, last element first
               new_count     = ADDR_W'(fill_ff - FILL_W'(loc_i));
               new_src       = head_ff + fill_lo - ADDR_W'(1);
               new_step_dn   = 1'b1;
               new_word_addr = head_ff + loc_i;
            end
         end
         KIND_DELETE: begin
            new_refused = (fill_ff == '0);
            new_fill    = fill_ff - FILL_W'(1);
            if (del_front) begin
               new_head    = head_ff + ADDR_W'(1);
               new_count   = loc_a;
               new_src     = phys_a - ADDR_W'(1);
               new_step_dn = 1'b1;
            end else begin
               new_count   = ADDR_W'(fill_ff - FILL_W'(1) - FILL_W'(loc_a));
               new_src     = phys_a + ADDR_W'(1);
               new_step_dn = 1'b0;
            end
         end
         KIND_SWAP: begin
            new_refused = (fill_ff < FILL_W'(2));
         end
         default: begin
            new_refused = 1'b0;
         end
      endcase
      if (new_refused) begin
         new_status = (req_bus.kind == KIND_INSERT) ? STAT_FULL : STAT_EMPTY;
         new_head   = head_ff;
         new_fill   = fill_ff;
      end
   end

   // next-state
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      src_in       = src_ff;
      count_in     = count_ff;
      step_dn_in   = step_dn_ff;
      word_addr_in = word_addr_ff;
      word_in      = word_ff;
      hold_in      = hold_ff;
      pend_in      = cmd.copy;
      pend_addr_in = step_dn_ff ? src_ff + ADDR_W'(1) : src_ff - ADDR_W'(1);
      if (cmd.accept) begin
         head_in      = new_head;
         fill_in      = new_fill;
         kind_in      = kind_type'(req_bus.kind);
         status_in    = new_status;
         addr_a_in    = phys_a;
         addr_b_in    = phys_b;
         src_in       = new_src;
         count_in     = new_count;
         step_dn_in   = new_step_dn;
         word_addr_in = new_word_addr;
         word_in      = req_bus.value;
      end
      if (cmd.copy) begin
         src_in   = step_dn_ff ? src_ff - ADDR_W'(1) : src_ff + ADDR_W'(1);
         count_in = count_ff - ADDR_W'(1);
      end
      if (cmd.capture) begin
         hold_in = ram_rd_data;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_fill_in   = fill_ff;
         rsp_status_in = status_ff;
         if (status_ff == STAT_DONE &&
             (kind_ff == KIND_GET || kind_ff == KIND_DELETE)) begin
            rsp_data_in = hold_ff;
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      addr_a_ff     <= addr_a_in;
      addr_b_ff     <= addr_b_in;
      src_ff        <= src_in;
      count_ff      <= count_in;
      step_dn_ff    <= step_dn_in;
      word_addr_ff  <= word_addr_in;
      word_ff       <= word_in;
      hold_ff       <= hold_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ram port muxing, at most one write source is active
   always_comb begin
      ram_rd_en   = cmd.rd_loc | cmd.rd_b | cmd.copy;
      ram_rd_addr = addr_a_ff;
      if (cmd.rd_b) begin
         ram_rd_addr = addr_b_ff;
      end else if (cmd.copy) begin
         ram_rd_addr = src_ff;
      end
      ram_wr_en   = pend_ff | cmd.wr_swap_a | cmd.wr_swap_b | cmd.wr_word;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = ram_rd_data;
      if (cmd.wr_swap_a) begin
         ram_wr_addr = addr_a_ff;
      end else if (cmd.wr_swap_b) begin
         ram_wr_addr = addr_b_ff;
         ram_wr_data = hold_ff;
      end else if (cmd.wr_word) begin
         ram_wr_addr = word_addr_ff;
         ram_wr_data = word_ff;
      end
   end

   prd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // status to controller
   always_comb begin
      stat.req_valid   = req_bus.valid;
      stat.new_kind    = kind_type'(req_bus.kind);
      stat.new_refused = new_refused;
      stat.new_no_copy = (new_count == '0);
      stat.cur_kind    = kind_ff;
      stat.cur_no_copy = (count_ff == '0);
      stat.cur_last    = (count_ff == ADDR_W'(1));
      stat.out_free    = !rsp_valid_ff || rsp_bus.ready;
   end

   assign req_bus.ready      = cmd.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = rsp_data_ff;
   assign rsp_bus.fill_level = rsp_fill_ff;
   assign rsp_bus.status     = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/core/positional_ring_deque_core.sv =====
`default_nettype none
// insert and delete shift the n words on the nearer side of the position by one slot
// throughput: one request at a time; the shift moves one word per cycle through
//   the single write / single read slot ram, so n is at most about capacity/2
// a finished response waits in its own register while the next request is taken
// reset (synchronous, active high) empties the list; slot contents are not cleared
// ----------------------------------------------------------------------------
// positional_ring_deque_core
// ordered list of words kept gap-free in a ring of slots, addressed by logical
// position: get, insert, delete and swap, one response per request
// ----------------------------------------------------------------------------
module positional_ring_deque_core import prd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   prd_req_if.sink   req_bus,
   prd_rsp_if.source rsp_bus
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: one-hot state machine that walks a request through
   // read, capture, shift copies, final writes and response load
   prd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: head and fill pointers, request decode (clamping, nearer
   // side choice), shift address walker, slot ram and response register
   prd_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

   // a refused request never returns a word
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STAT_DONE |-> rsp_bus.read_data == '0)
      else $error("read word on refused request");

   // full is only reported with the list at capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STAT_FULL
      |-> rsp_bus.fill_level == FILL_W'(CAPACITY))
      else $error("full status below capacity");

   // the fill level never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.fill_level <= FILL_W'(CAPACITY))
      else $error("fill level beyond capacity");

   // a response is loaded only while the request port is closed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(!req_bus.ready))
      else $error("response loaded while idle");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the positional ring deque: a queue-based driver and
// a response monitor check every response against a logical list model
// ----------------------------------------------------------------------------
module testbench import prd_pkg::*; ();

   // one request as the driver sends it
   typedef struct {
      kind_type              kind;
      logic [POS_W-1:0]      position;
      logic [POS_W-1:0]      second_position;
      logic [DATA_WIDTH-1:0] value;
   } req_item_type;

   // one response as the list model predicts it
   typedef struct {
      logic [DATA_WIDTH-1:0] read_data;
      logic [FILL_W-1:0]     fill_level;
      status_type            status;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset;

   prd_req_if req_bus ();
   prd_rsp_if rsp_bus ();

   positional_ring_deque_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_item_type          pending_reqs[$];   // requests not yet offered
   rsp_item_type          expected_rsp[$];   // responses still owed, oldest first
   logic [DATA_WIDTH-1:0] list_words[$];     // logical contents, front at index 0

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures      = 0;

   // generation-time view of the fill level, steers the random mix
   int gen_fill    = 0;
   bit gen_filling = 1'b1;

   // coverage tallies for the summary
   int kind_seen[4];
   int full_refusals  = 0;
   int empty_refusals = 0;
   int peak_fill      = 0;
   int rsp_checked    = 0;

   // positions past the end refer to the last element
   function automatic int clamp_last(logic [POS_W-1:0] pos, int n);
      return (pos >= n) ? n - 1 : int'(pos);
   endfunction

   // apply one request to the logical list and return what the block must answer;
   // which side moves on insert or delete never shows in the logical order
   function automatic rsp_item_type deque_outcome(req_item_type r);
      rsp_item_type          o;
      int                    n;
      int                    a;
      int                    b;
      logic [DATA_WIDTH-1:0] held;
      n           = list_words.size();
      o.read_data = '0;
      o.status    = STAT_DONE;
      case (r.kind)
         KIND_GET: begin
            if (n == 0) o.status = STAT_EMPTY;
            else o.read_data = list_words[clamp_last(r.position, n)];
         end
         KIND_INSERT: begin
            if (n >= CAPACITY) begin
               o.status = STAT_FULL;
            end else begin
               // past the fill level appends at the end
               a = (r.position > n) ? n : int'(r.position);
               list_words.insert(a, r.value);
            end
         end
         KIND_DELETE: begin
            if (n == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               a           = clamp_last(r.position, n);
               o.read_data = list_words[a];
               list_words.delete(a);
            end
         end
         default: begin
            // swap needs two elements; a swap with itself is a no-op
            if (n < 2) begin
               o.status = STAT_EMPTY;
            end else begin
               a             = clamp_last(r.position, n);
               b             = clamp_last(r.second_position, n);
               held          = list_words[a];
               list_words[a] = list_words[b];
               list_words[b] = held;
            end
         end
      endcase
      o.fill_level = FILL_W'(list_words.size());
      return o;
   endfunction

   function automatic void push_item(kind_type k, int pos, int pos2, logic [31:0] val);
      req_item_type r;
      r.kind            = k;
      r.position        = POS_W'(pos);
      r.second_position = POS_W'(pos2);
      r.value           = val;
      pending_reqs.push_back(r);
      if (k == KIND_INSERT && gen_fill < CAPACITY) gen_fill++;
      if (k == KIND_DELETE && gen_fill > 0) gen_fill--;
   endfunction

   // mostly live positions, plus the front and past-the-end cases
   function automatic int rand_position(int fill);
      case ($urandom_range(0, 9))
         7:       return 0;
         8:       return $urandom_range(0, CAPACITY);
         9:       return CAPACITY;
         default: return $urandom_range(0, fill);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // random requests that sweep the list from empty to full and back
   task automatic queue_random(int count);
      int       w;
      kind_type k;
      for (int i = 0; i < count; i++) begin
         // linger at the ends so full and empty refusals occur repeatedly
         if (gen_filling && gen_fill == CAPACITY && $urandom_range(0, 7) == 0)
            gen_filling = 1'b0;
         else if (!gen_filling && gen_fill == 0 && $urandom_range(0, 7) == 0)
            gen_filling = 1'b1;
         w = $urandom_range(0, 99);
         if (w < 55)      k = gen_filling ? KIND_INSERT : KIND_DELETE;
         else if (w < 70) k = gen_filling ? KIND_DELETE : KIND_INSERT;
         else if (w < 85) k = KIND_GET;
         else             k = KIND_SWAP;
         push_item(k, rand_position(gen_fill), rand_position(gen_fill), rand_word());
      end
   endtask

   // hold off until every queued request has gone out and been answered
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // driver: a new request goes out only once the previous one was taken
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_bus.valid           <= 1'b0;
         req_bus.kind            <= KIND_GET;
         req_bus.position        <= '0;
         req_bus.second_position <= '0;
         req_bus.value           <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt                     = pending_reqs.pop_front();
            req_bus.kind            <= nxt.kind;
            req_bus.position        <= nxt.position;
            req_bus.second_position <= nxt.second_position;
            req_bus.value           <= nxt.value;
            req_bus.valid           <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: check the response first, then predict the request taken at the
   // same edge, since that response always belongs to an older request
   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type seen;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected response, expected none, actual %h/%0d/%0d",
                        $time, rsp_bus.read_data, rsp_bus.fill_level, rsp_bus.status);
            end else begin
               want = expected_rsp.pop_front();
               rsp_checked++;
               check_field("read_data", want.read_data, rsp_bus.read_data);
               check_field("fill_level", 32'(want.fill_level), 32'(rsp_bus.fill_level));
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.kind            = kind_type'(req_bus.kind);
            seen.position        = req_bus.position;
            seen.second_position = req_bus.second_position;
            seen.value           = req_bus.value;
            want                 = deque_outcome(seen);
            expected_rsp.push_back(want);
            kind_seen[seen.kind]++;
            if (want.status == STAT_FULL)  full_refusals++;
            if (want.status == STAT_EMPTY) empty_refusals++;
            if (int'(want.fill_level) > peak_fill) peak_fill = int'(want.fill_level);
         end
      end
   end

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase one: slow sender, very slow receiver
      send_idle_pct = 36;
      recv_idle_pct = 76;

      // refusals on an empty list
      push_item(KIND_GET,    0,  0, '0);
      push_item(KIND_DELETE, 0,  0, '0);
      push_item(KIND_SWAP,   0,  1, '0);
      // append past the end, then swap with a single element
      push_item(KIND_INSERT, CAPACITY, 0, '1);
      push_item(KIND_SWAP,   0, CAPACITY, '0);
      push_item(KIND_GET,    CAPACITY, 0, '0);
      // front, back and middle inserts, both moving sides
      push_item(KIND_INSERT, 0,  0, '0);
      push_item(KIND_INSERT, 1,  0, 32'hA5A5_A5A5);
      push_item(KIND_INSERT, CAPACITY, 0, 32'h5A5A_5A5A);
      push_item(KIND_INSERT, 2,  0, 32'h0123_4567);
      push_item(KIND_INSERT, 1,  0, 32'h89AB_CDEF);
      // swap across the ends, swap with itself, and reads
      push_item(KIND_SWAP,   0, CAPACITY, '0);
      push_item(KIND_SWAP,   2,  2, '0);
      push_item(KIND_GET,    0,  0, '0);
      push_item(KIND_GET,    3,  0, '0);
      // deletes past the end, at the front and in the middle
      push_item(KIND_DELETE, CAPACITY, 0, '0);
      push_item(KIND_DELETE, 0,  0, '0);
      push_item(KIND_DELETE, 1,  0, '0);
      push_item(KIND_DELETE, 1,  0, '0);
      push_item(KIND_DELETE, 0,  0, '0);
      push_item(KIND_DELETE, 0,  0, '0);
      queue_random(210);
      wait_drained();

      // phase two: very slow sender, slow receiver
      send_idle_pct = 76;
      recv_idle_pct = 36;
      queue_random(210);
      wait_drained();

      // phase three: back-to-back traffic
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(210);
      wait_drained();

      // room for any stray response after the last expected one
      repeat (80) @(posedge clock);

      $display("covered %0d responses: %0d get, %0d insert, %0d delete, %0d swap",
               rsp_checked, kind_seen[KIND_GET], kind_seen[KIND_INSERT],
               kind_seen[KIND_DELETE], kind_seen[KIND_SWAP]);
      $display("peak fill %0d of %0d, %0d full refusals, %0d empty or short refusals",
               peak_fill, CAPACITY, full_refusals, empty_refusals);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2400000;
      $display("timeout with %0d responses outstanding", expected_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== positional_ring_deque_core.f =====
rtl/core/prd_pkg.sv
rtl/core/prd_req_if.sv
rtl/core/prd_rsp_if.sv
rtl/core/prd_ram.sv
rtl/core/prd_ctrl.sv
rtl/core/prd_datapath.sv
rtl/core/positional_ring_deque_core.sv
bench/testbench.sv
